// File: hw/rtl/cpct_pkg.sv
// Package for the collider pair contact tracker.
// Shared constants, state and event types; no dependencies.
`default_nettype none

package cpct_pkg;

    localparam int MAX_COLLIDERS = 64;
    localparam int ROW_AW        = $clog2(MAX_COLLIDERS);
    localparam int ID_W          = 6;
    localparam int POS_W         = 24;
    localparam int SIZE_W        = 16;
    localparam int SCALE_W       = 8;
    localparam int HALF_W        = SIZE_W + SCALE_W;
    localparam int MW            = 26;
    localparam int PW            = 2 * MW;
    localparam int AXW           = 28;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd100;
    localparam logic               KIND_CIRCLE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_LW,
        S_MUL_LH,
        S_MUL_RW,
        S_MUL_RH,
        S_AXIS_X,
        S_AXIS_Y,
        S_SQ_DX,
        S_SQ_DY,
        S_SQ_RS,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } t_event;

endpackage

`default_nettype wire

// File: hw/rtl/cpct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cpct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/collider_pair_contact_tracker_core.sv
// Collider pair contact tracker, top level.
// Uses cpct_pkg and cpct_ram (contact table rows).
//
// One pair word is taken when o_in_ready is high, which is whenever the
// sequencer is idle. Sizes are scaled and all tests run on one shared
// 26x26 multiplier and one shared per-axis add/compare unit: each pair
// runs the size multiplies and both axis steps, circle-circle pairs then
// also square dx, dy and the radius sum before going idle. The result
// sits in an output register, so the next pair is accepted while it waits.
// The contact table is a 64-row RAM with one valid bit per row that reset
// clears, so the block is ready right after reset with no clearing pass.
`default_nettype none

module collider_pair_contact_tracker_core
    import cpct_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [SCALE_W-1:0]  i_cfg_wr_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [ID_W-1:0]     i_left_id,
    input  wire logic [ID_W-1:0]     i_right_id,
    input  wire logic                i_left_kind,
    input  wire logic                i_right_kind,
    input  wire logic signed [POS_W-1:0] i_left_x,
    input  wire logic signed [POS_W-1:0] i_left_y,
    input  wire logic [SIZE_W-1:0]   i_left_w,
    input  wire logic [SIZE_W-1:0]   i_left_h,
    input  wire logic signed [POS_W-1:0] i_right_x,
    input  wire logic signed [POS_W-1:0] i_right_y,
    input  wire logic [SIZE_W-1:0]   i_right_w,
    input  wire logic [SIZE_W-1:0]   i_right_h,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [1:0]               o_contact_event,
    output logic                     o_overlapping
);

    t_state r_state, n_state;

    logic [SCALE_W-1:0] r_scale;
    logic [ID_W-1:0]    r_lid, r_rid;
    logic               r_lk, r_rk;
    logic signed [POS_W-1:0] r_lx, r_ly, r_rx, r_ry;
    logic [SIZE_W-1:0]  r_lw, r_lh, r_rw, r_rh;
    logic [HALF_W-1:0]  r_lhw, r_lhh, r_rhw, r_rhh;
    logic [MW-1:0]      r_dx, r_dy, r_rs;
    logic               r_ax_ok;
    logic [PW-1:0]      r_prod;
    logic [PW:0]        r_acc;
    logic               r_out_vld;
    t_event             r_out_ev;
    logic               r_out_hit;
    logic               r_row_vld [MAX_COLLIDERS];

    logic in_acc;
    logic done_go;

    // shared multiplier
    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;

    // shared axis unit
    logic signed [POS_W-1:0]  ax_pl, ax_pr;
    logic [HALF_W-1:0]        ax_hl_u, ax_hr_u;
    logic signed [AXW-1:0]    ax_d, ax_hl, ax_hr, ax_sum, ax_c, ax_cabs;
    logic                     ax_box_ok, ax_mix_ok, ax_ok;
    logic [MW-1:0]            ax_abs;

    // decision and table
    logic                 both_circ, mixed, hit, prev, pair_ok;
    logic [ROW_AW-1:0]    row_addr;
    logic [ROW_AW-1:0]    bit_idx;
    logic [MAX_COLLIDERS-1:0] ram_rdata, row_cur, row_new;
    logic                 ram_we;
    t_event               ev;

    assign in_acc   = i_in_valid && o_in_ready;
    assign done_go  = (r_state == S_DONE) && (!r_out_vld || i_out_ready);
    assign both_circ = (r_lk == KIND_CIRCLE) && (r_rk == KIND_CIRCLE);
    assign mixed     = (r_lk != r_rk);

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_vld;
    assign o_contact_event = r_out_ev;
    assign o_overlapping   = r_out_hit;

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        mul_a   = r_dx;
        mul_b   = r_dx;
        ram_we  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_MUL_LW;
                end
            end
            S_MUL_LW: begin
                mul_a   = {{(MW-SIZE_W){1'b0}}, r_lw};
                mul_b   = {{(MW-SCALE_W){1'b0}}, r_scale};
                n_state = S_MUL_LH;
            end
            S_MUL_LH: begin
                mul_a   = {{(MW-SIZE_W){1'b0}}, r_lh};
                mul_b   = {{(MW-SCALE_W){1'b0}}, r_scale};
                n_state = S_MUL_RW;
            end
            S_MUL_RW: begin
                mul_a   = {{(MW-SIZE_W){1'b0}}, r_rw};
                mul_b   = {{(MW-SCALE_W){1'b0}}, r_scale};
                n_state = S_MUL_RH;
            end
            S_MUL_RH: begin
                mul_a   = {{(MW-SIZE_W){1'b0}}, r_rh};
                mul_b   = {{(MW-SCALE_W){1'b0}}, r_scale};
                n_state = S_AXIS_X;
            end
            S_AXIS_X: begin
                n_state = S_AXIS_Y;
            end
            S_AXIS_Y: begin
                n_state = both_circ ? S_SQ_DX : S_DONE;
            end
            S_SQ_DX: begin
                mul_a   = r_dx;
                mul_b   = r_dx;
                n_state = S_SQ_DY;
            end
            S_SQ_DY: begin
                mul_a   = r_dy;
                mul_b   = r_dy;
                n_state = S_SQ_RS;
            end
            S_SQ_RS: begin
                mul_a   = r_rs;
                mul_b   = r_rs;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (done_go) begin
                    ram_we  = pair_ok;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // per-axis unit: x in S_AXIS_X, y otherwise
    always_comb begin
        if (r_state == S_AXIS_X) begin
            ax_pl   = r_lx;
            ax_pr   = r_rx;
            ax_hl_u = r_lhw;
            ax_hr_u = r_rhw;
        end else begin
            ax_pl   = r_ly;
            ax_pr   = r_ry;
            ax_hl_u = r_lhh;
            ax_hr_u = r_rhh;
        end
        ax_d = ({{(AXW-POS_W){ax_pl[POS_W-1]}}, ax_pl}
              - {{(AXW-POS_W){ax_pr[POS_W-1]}}, ax_pr}) <<< 1;
        ax_hl  = {{(AXW-HALF_W){1'b0}}, ax_hl_u};
        ax_hr  = {{(AXW-HALF_W){1'b0}}, ax_hr_u};
        ax_sum = ax_hl + ax_hr;
        ax_box_ok = (ax_d < ax_sum) && (ax_d > -ax_sum);
        ax_mix_ok = (ax_d < (ax_hr <<< 1)) && (ax_d > -(ax_hl <<< 1));
        ax_ok   = mixed ? ax_mix_ok : ax_box_ok;
        ax_c    = ax_d + ax_hl - ax_hr;
        ax_cabs = ax_c[AXW-1] ? -ax_c : ax_c;
        ax_abs  = ax_cabs[MW-1:0];
    end

    // contact table
    assign row_addr = ROW_AW'(r_lid);
    assign bit_idx  = ROW_AW'(r_rid);
    assign pair_ok  = (r_lid != r_rid) && (32'(r_lid) < MAX_COLLIDERS)
                      && (32'(r_rid) < MAX_COLLIDERS);

    cpct_ram #(
        .WIDTH (MAX_COLLIDERS),
        .DEPTH (MAX_COLLIDERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (row_addr),
        .i_wdata (row_new),
        .i_re    (in_acc),
        .i_raddr (ROW_AW'(i_left_id)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        row_cur = r_row_vld[row_addr] ? ram_rdata : '0;
        prev    = row_cur[bit_idx];
        hit     = both_circ ? (r_acc < {1'b0, r_prod}) : r_ax_ok;
        row_new = row_cur;
        row_new[bit_idx] = hit;
        ev = EV_NONE;
        if (pair_ok) begin
            if (hit) begin
                ev = prev ? EV_STAY : EV_ENTER;
            end else if (prev) begin
                ev = EV_EXIT;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= SCALE_RESET;
            r_out_vld <= 1'b0;
            for (int i = 0; i < MAX_COLLIDERS; i++) begin
                r_row_vld[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_scale <= i_cfg_wr_data;
            end
            if (done_go) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (ram_we) begin
                r_row_vld[row_addr] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lid <= i_left_id;
            r_rid <= i_right_id;
            r_lk  <= i_left_kind;
            r_rk  <= i_right_kind;
            r_lx  <= i_left_x;
            r_ly  <= i_left_y;
            r_rx  <= i_right_x;
            r_ry  <= i_right_y;
            r_lw  <= i_left_w;
            r_lh  <= i_left_h;
            r_rw  <= i_right_w;
            r_rh  <= i_right_h;
        end
        case (r_state)
            S_MUL_LW: r_lhw <= mul_p[HALF_W-1:0];
            S_MUL_LH: r_lhh <= mul_p[HALF_W-1:0];
            S_MUL_RW: r_rhw <= mul_p[HALF_W-1:0];
            S_MUL_RH: r_rhh <= mul_p[HALF_W-1:0];
            S_AXIS_X: begin
                r_ax_ok <= ax_ok;
                r_dx    <= ax_abs;
                r_rs    <= ax_sum[MW-1:0];
            end
            S_AXIS_Y: begin
                r_ax_ok <= r_ax_ok && ax_ok;
                r_dy    <= ax_abs;
            end
            S_SQ_DX: r_prod <= mul_p;
            S_SQ_DY: begin
                r_acc  <= {1'b0, r_prod};
                r_prod <= mul_p;
            end
            S_SQ_RS: begin
                r_acc  <= r_acc + {1'b0, r_prod};
                r_prod <= mul_p;
            end
            default: begin
            end
        endcase
        if (done_go) begin
            r_out_ev  <= ev;
            r_out_hit <= hit;
        end
    end

    a_enter_stay_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_ev == EV_ENTER || r_out_ev == EV_STAY)) |-> r_out_hit)
        else $error("enter/stay word without overlap");

    a_exit_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_ev == EV_EXIT) |-> !r_out_hit)
        else $error("exit word with overlap");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_MUL_LW))
        else $error("accepted word did not start sequencer");

    a_row_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_row_vld[$past(row_addr)])
        else $error("written row not marked valid");

    a_equal_ids_untouched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_lid == r_rid) |-> !ram_we)
        else $error("table written for equal ids");

endmodule

`default_nettype wire

// File: tb/collider_pair_contact_tracker_checker.sv
// Scoreboard for collider_pair_contact_tracker_core: watches config, pair and
// result channels, predicts overlap and contact events, compares results.
// Depends on cpct_pkg for widths and the event encoding.
`timescale 1ns / 100ps

module collider_pair_contact_tracker_checker
    import cpct_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [SCALE_W-1:0]      i_cfg_wr_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [ID_W-1:0]         i_left_id,
    input  logic [ID_W-1:0]         i_right_id,
    input  logic                    i_left_kind,
    input  logic                    i_right_kind,
    input  logic signed [POS_W-1:0] i_left_x,
    input  logic signed [POS_W-1:0] i_left_y,
    input  logic [SIZE_W-1:0]       i_left_w,
    input  logic [SIZE_W-1:0]       i_left_h,
    input  logic signed [POS_W-1:0] i_right_x,
    input  logic signed [POS_W-1:0] i_right_y,
    input  logic [SIZE_W-1:0]       i_right_w,
    input  logic [SIZE_W-1:0]       i_right_h,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [1:0]              i_contact_event,
    input  logic                    i_overlapping,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        t_event ev;
        logic   hit;
    } contact_word_t;

    localparam int TABLE_DEPTH = MAX_COLLIDERS * MAX_COLLIDERS;

    logic              contact_bits [0:TABLE_DEPTH-1];
    logic [SCALE_W-1:0] scale_q;
    contact_word_t     expected_contacts [$];

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // circle centre strictly inside the box (top-left origin) grown by the half size
    function automatic bit inside_grown_box(input longint bx, by, bw, bh,
                                            input longint cx, cy, chw, chh);
        return cx > bx - chw && cx < bx + bw + chw &&
               cy > by - chh && cy < by + bh + chh;
    endfunction

    // all coordinates doubled: units of 1/512, half scaled size = raw * scale
    function automatic bit pair_overlaps(input logic lk, rk,
                                         input longint lx, ly, rx, ry,
                                         input longint lhw, lhh, rhw, rhh);
        longint dx, dy, rs;
        if (lk != KIND_CIRCLE && rk != KIND_CIRCLE)
            return mag(lx - rx) < lhw + rhw && mag(ly - ry) < lhh + rhh;
        if (lk == KIND_CIRCLE && rk == KIND_CIRCLE) begin
            dx = mag((lx + lhw) - (rx + rhw));
            dy = mag((ly + lhh) - (ry + rhh));
            rs = lhw + rhw;
            return dx * dx + dy * dy < rs * rs;
        end
        if (lk != KIND_CIRCLE)
            return inside_grown_box(lx, ly, 2 * lhw, 2 * lhh, rx + rhw, ry + rhh, rhw, rhh);
        return inside_grown_box(rx, ry, 2 * rhw, 2 * rhh, lx + lhw, ly + lhh, lhw, lhh);
    endfunction

    always @(posedge i_clk) begin
        contact_word_t    w;
        contact_word_t    got;
        logic [2*ID_W-1:0] key;
        longint           sc;
        if (!i_rst_n) begin
            scale_q = SCALE_RESET;
            for (int i = 0; i < TABLE_DEPTH; i++) contact_bits[i] = 1'b0;
            expected_contacts.delete();
            o_pending    = 0;
            o_fail_count = 0;
        end else begin
            if (i_cfg_wr_en) scale_q = i_cfg_wr_data;
            if (i_in_valid && i_in_ready) begin
                sc    = longint'(scale_q);
                w.hit = pair_overlaps(i_left_kind, i_right_kind,
                                      2 * longint'(i_left_x), 2 * longint'(i_left_y),
                                      2 * longint'(i_right_x), 2 * longint'(i_right_y),
                                      longint'(i_left_w) * sc, longint'(i_left_h) * sc,
                                      longint'(i_right_w) * sc, longint'(i_right_h) * sc);
                w.ev  = EV_NONE;
                key   = {i_left_id, i_right_id};
                if (i_left_id != i_right_id && i_left_id < MAX_COLLIDERS &&
                    i_right_id < MAX_COLLIDERS) begin
                    if (w.hit) begin
                        w.ev = contact_bits[key] ? EV_STAY : EV_ENTER;
                        contact_bits[key] = 1'b1;
                    end else if (contact_bits[key]) begin
                        w.ev = EV_EXIT;
                        contact_bits[key] = 1'b0;
                    end
                end
                expected_contacts.push_back(w);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_contacts.size() == 0) begin
                    $error("result word with no pair pending: contact_event %0d overlapping %0d",
                           i_contact_event, i_overlapping);
                    o_fail_count++;
                end else begin
                    got = expected_contacts.pop_front();
                    if (i_contact_event !== got.ev) begin
                        $error("contact_event: expected %0d, actual %0d",
                               got.ev, i_contact_event);
                        o_fail_count++;
                    end
                    if (i_overlapping !== got.hit) begin
                        $error("overlapping: expected %0d, actual %0d",
                               got.hit, i_overlapping);
                        o_fail_count++;
                    end
                end
            end
            o_pending = expected_contacts.size();
        end
    end

endmodule

// File: tb/collider_pair_contact_tracker_core_tb.sv
// Top of the collider_pair_contact_tracker_core testbench: clock, reset,
// pair and config stimulus, receiver stalls and verdict.
// Depends on cpct_pkg, the core and collider_pair_contact_tracker_checker.
`timescale 1ns / 100ps

module collider_pair_contact_tracker_core_tb;
    import cpct_pkg::*;

    localparam logic KIND_BOX    = ~KIND_CIRCLE;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   PHASE_PAIRS = 190;
    localparam int   NUM_PHASES  = 6;
    localparam int   HOLD_CYCLES = 600;

    typedef struct {
        logic [ID_W-1:0]         left_id;
        logic [ID_W-1:0]         right_id;
        logic                    left_kind;
        logic                    right_kind;
        logic signed [POS_W-1:0] left_x;
        logic signed [POS_W-1:0] left_y;
        logic [SIZE_W-1:0]       left_w;
        logic [SIZE_W-1:0]       left_h;
        logic signed [POS_W-1:0] right_x;
        logic signed [POS_W-1:0] right_y;
        logic [SIZE_W-1:0]       right_w;
        logic [SIZE_W-1:0]       right_h;
    } pair_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [SCALE_W-1:0]      i_cfg_wr_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [ID_W-1:0]         i_left_id;
    logic [ID_W-1:0]         i_right_id;
    logic                    i_left_kind;
    logic                    i_right_kind;
    logic signed [POS_W-1:0] i_left_x;
    logic signed [POS_W-1:0] i_left_y;
    logic [SIZE_W-1:0]       i_left_w;
    logic [SIZE_W-1:0]       i_left_h;
    logic signed [POS_W-1:0] i_right_x;
    logic signed [POS_W-1:0] i_right_y;
    logic [SIZE_W-1:0]       i_right_w;
    logic [SIZE_W-1:0]       i_right_h;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [1:0]              o_contact_event;
    logic                    o_overlapping;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int phase_num   = 0;
    int burst_left  = 0;
    bit gaps_on     = 1'b1;

    collider_pair_contact_tracker_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_left_id       (i_left_id),
        .i_right_id      (i_right_id),
        .i_left_kind     (i_left_kind),
        .i_right_kind    (i_right_kind),
        .i_left_x        (i_left_x),
        .i_left_y        (i_left_y),
        .i_left_w        (i_left_w),
        .i_left_h        (i_left_h),
        .i_right_x       (i_right_x),
        .i_right_y       (i_right_y),
        .i_right_w       (i_right_w),
        .i_right_h       (i_right_h),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_contact_event (o_contact_event),
        .o_overlapping   (o_overlapping)
    );

    collider_pair_contact_tracker_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_left_id       (i_left_id),
        .i_right_id      (i_right_id),
        .i_left_kind     (i_left_kind),
        .i_right_kind    (i_right_kind),
        .i_left_x        (i_left_x),
        .i_left_y        (i_left_y),
        .i_left_w        (i_left_w),
        .i_left_h        (i_left_h),
        .i_right_x       (i_right_x),
        .i_right_y       (i_right_y),
        .i_right_w       (i_right_w),
        .i_right_h       (i_right_h),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_contact_event (o_contact_event),
        .i_overlapping   (o_overlapping),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("collider_pair_contact_tracker_core regression: fail");
            $finish;
        end
    end

    // receiver: one long hold-off at the start of each random phase, then
    // changing stall patterns
    initial begin
        int hold_left;
        int hold_phase;
        int mode_left;
        int stall_mode;
        hold_left   = 0;
        hold_phase  = 0;
        mode_left   = 0;
        stall_mode  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else if (hold_phase != phase_num) begin
                hold_phase  = phase_num;
                hold_left   = HOLD_CYCLES;
                i_out_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(16, 96);
                end
                mode_left--;
                case (stall_mode)
                    0: i_out_ready = 1'b1;
                    1: i_out_ready = 1'($urandom_range(0, 1));
                    2: i_out_ready = ($urandom_range(0, 3) == 0);
                    default: i_out_ready = ((cycle_count % 7) < 3);
                endcase
            end
        end
    end

    function automatic pair_t mk(input int lid, rid, input logic lk, rk,
                                 input int lx, ly, lw, lh, rx, ry, rw, rh);
        pair_t p;
        p.left_id  = ID_W'(lid);
        p.right_id = ID_W'(rid);
        p.left_kind  = lk;
        p.right_kind = rk;
        p.left_x  = POS_W'(lx);
        p.left_y  = POS_W'(ly);
        p.left_w  = SIZE_W'(lw);
        p.left_h  = SIZE_W'(lh);
        p.right_x = POS_W'(rx);
        p.right_y = POS_W'(ry);
        p.right_w = SIZE_W'(rw);
        p.right_h = SIZE_W'(rh);
        return p;
    endfunction

    // mostly pairs from a small ID pool placed near each other, some noise
    function automatic pair_t gen_pair(input logic [SCALE_W-1:0] scale);
        pair_t       p;
        int          span;
        int          base;
        int unsigned r;
        int unsigned szmax;
        if ($urandom_range(0, 6) == 0) begin
            p.left_id    = ID_W'($urandom);
            p.right_id   = ID_W'($urandom);
            p.left_kind  = 1'($urandom);
            p.right_kind = 1'($urandom);
            p.left_x  = POS_W'($urandom);
            p.left_y  = POS_W'($urandom);
            p.left_w  = SIZE_W'($urandom);
            p.left_h  = SIZE_W'($urandom);
            p.right_x = POS_W'($urandom);
            p.right_y = POS_W'($urandom);
            p.right_w = SIZE_W'($urandom);
            p.right_h = SIZE_W'($urandom);
            return p;
        end
        p.left_id    = ($urandom_range(0, 4) == 0) ? ID_W'($urandom)
                                                   : ID_W'($urandom_range(0, 5));
        p.right_id   = ($urandom_range(0, 4) == 0) ? ID_W'($urandom)
                                                   : ID_W'($urandom_range(0, 5));
        p.left_kind  = 1'($urandom);
        p.right_kind = 1'($urandom);
        r     = $urandom_range(0, 9);
        szmax = (r < 5) ? 1023 : (r < 9) ? 8191 : 65535;
        p.left_w  = SIZE_W'($urandom_range(0, szmax));
        p.left_h  = SIZE_W'($urandom_range(0, szmax));
        p.right_w = SIZE_W'($urandom_range(0, szmax));
        p.right_h = SIZE_W'($urandom_range(0, szmax));

        span = ((int'(p.left_w) + int'(p.right_w)) * int'(scale)) / 4 + 64;
        if (span > 2000000) span = 2000000;
        base = int'($urandom_range(0, 8000000)) - 4000000;
        p.left_x  = POS_W'(base);
        p.right_x = POS_W'(base + int'($urandom_range(0, 4 * span)) - 2 * span);

        span = ((int'(p.left_h) + int'(p.right_h)) * int'(scale)) / 4 + 64;
        if (span > 2000000) span = 2000000;
        base = int'($urandom_range(0, 8000000)) - 4000000;
        p.left_y  = POS_W'(base);
        p.right_y = POS_W'(base + int'($urandom_range(0, 4 * span)) - 2 * span);
        return p;
    endfunction

    task automatic send_pair(input pair_t p);
        i_left_id    = p.left_id;
        i_right_id   = p.right_id;
        i_left_kind  = p.left_kind;
        i_right_kind = p.right_kind;
        i_left_x  = p.left_x;
        i_left_y  = p.left_y;
        i_left_w  = p.left_w;
        i_left_h  = p.left_h;
        i_right_x = p.right_x;
        i_right_y = p.right_y;
        i_right_w = p.right_w;
        i_right_h = p.right_h;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (gaps_on && $urandom_range(0, 3) != 0) begin
                i_in_valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] v);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    initial begin
        logic [SCALE_W-1:0] scale_set;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_left_id     = '0;
        i_right_id    = '0;
        i_left_kind   = KIND_BOX;
        i_right_kind  = KIND_BOX;
        i_left_x      = '0;
        i_left_y      = '0;
        i_left_w      = '0;
        i_left_h      = '0;
        i_right_x     = '0;
        i_right_y     = '0;
        i_right_w     = '0;
        i_right_h     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed, at the reset scale
        send_pair(mk(1, 2, KIND_BOX, KIND_BOX, 0, 0, 256, 256, 1000, 0, 256, 256));
        send_pair(mk(1, 2, KIND_BOX, KIND_BOX, 0, 0, 256, 256, 1000, 0, 256, 256));
        send_pair(mk(1, 2, KIND_BOX, KIND_BOX, 0, 0, 256, 256, 25600, 0, 256, 256));
        send_pair(mk(1, 2, KIND_BOX, KIND_BOX, 0, 0, 256, 256, 25599, 0, 256, 256));
        send_pair(mk(1, 2, KIND_BOX, KIND_BOX, 0, 0, 256, 256, 0, -25600, 256, 256));
        send_pair(mk(2, 1, KIND_BOX, KIND_BOX, 0, 0, 256, 256, 1000, 0, 256, 256));
        send_pair(mk(5, 5, KIND_BOX, KIND_BOX, 0, 0, 256, 256, 0, 0, 256, 256));
        send_pair(mk(3, 4, KIND_CIRCLE, KIND_CIRCLE, 0, 0, 512, 512, 30000, 30000, 512, 512));
        send_pair(mk(3, 4, KIND_CIRCLE, KIND_CIRCLE, 0, 0, 512, 512, 72000, 72000, 512, 512));
        send_pair(mk(6, 7, KIND_BOX, KIND_CIRCLE, 0, 0, 256, 256, 100, 100, 128, 128));
        send_pair(mk(7, 6, KIND_CIRCLE, KIND_BOX, 100, 100, 128, 128, 0, 0, 256, 256));
        send_pair(mk(6, 7, KIND_BOX, KIND_CIRCLE, 0, 0, 256, 256, -20000, 0, 128, 128));
        send_pair(mk(8, 9, KIND_BOX, KIND_BOX, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(mk(8, 9, KIND_CIRCLE, KIND_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(mk(8, 9, KIND_CIRCLE, KIND_BOX, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(mk(63, 0, KIND_BOX, KIND_BOX, -8388608, -8388608, 65535, 65535,
                     8388607, 8388607, 65535, 65535));
        send_pair(mk(63, 0, KIND_CIRCLE, KIND_CIRCLE, 8388607, -8388608, 65535, 65535,
                     8388607, -8388608, 65535, 65535));
        send_pair(mk(0, 63, KIND_CIRCLE, KIND_BOX, -8388608, 8388607, 65535, 0,
                     8388607, -8388608, 0, 65535));
        send_pair(mk(63, 63, KIND_CIRCLE, KIND_CIRCLE, 8388607, 8388607, 65535, 65535,
                     8388607, 8388607, 65535, 65535));
        send_pair(mk(63, 0, KIND_CIRCLE, KIND_CIRCLE, -8388608, -8388608, 1, 1,
                     8388607, 8388607, 1, 1));
        send_pair(mk(62, 61, KIND_CIRCLE, KIND_CIRCLE, -1, -1, 65535, 65535,
                     -1, -1, 65535, 65535));
        send_pair(mk(0, 0, KIND_BOX, KIND_BOX, 0, 0, 0, 0, 0, 0, 0, 0));

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                1: scale_set = 8'd255;
                2: scale_set = 8'd1;
                3: scale_set = 8'd0;
                4: scale_set = SCALE_W'($urandom_range(2, 254));
                5: scale_set = SCALE_RESET;
                default: scale_set = SCALE_W'($urandom);
            endcase
            write_scale(scale_set);
            phase_num = ph;
            gaps_on   = (ph != 4);
            repeat (PHASE_PAIRS) send_pair(gen_pair(scale_set));
        end

        wait_drained();
        repeat (16) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("collider_pair_contact_tracker_core regression: pass");
        end else begin
            $display("collider_pair_contact_tracker_core regression: fail");
        end
        $finish;
    end

endmodule
